// ===== rtl/rtpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpd_pkg
// Shared constants, register indexes and interface types of the RC throttle
// pulse decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpd_pkg;

  // Bad-pulse limits in microseconds and the command offset at center.
  localparam int PULSE_BAD_MIN = 700;
  localparam int PULSE_BAD_MAX = 2400;
  localparam int CENTER_ADJUST = 0;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int PW_W      = 16;
  localparam int CMD_W     = 9;

  // Divider sizing: |numerator * delta| stays below 2^22 and |span| below 2^13.
  localparam int DIV_W = 22;
  localparam int DEN_W = 13;
  localparam int CNT_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_CENTER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FORWARD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REVERSE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_CHANNEL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_SHIFT = 3'd7;

  typedef struct packed {
    logic [11:0] pulse_min;
    logic [11:0] pulse_center;
    logic [11:0] pulse_max;
    logic [9:0]  deadband;
    logic [7:0]  max_forward;
    logic [8:0]  max_reverse;      // two's complement
    logic        reverse_channel;
    logic [2:0]  smoothing_shift;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic mult;
    logic div_step;
    logic raw;
    logic result;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rtpd_cfg.sv =====
// ----------------------------------------------------------------------------
// rtpd_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpd_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [rtpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rtpd_pkg::CFG_W-1:0]       cfg_data,
  output rtpd_pkg::cfg_t                        cfg
);

  rtpd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_min       <= 12'd1000;
      cfg_r.pulse_center    <= 12'd1500;
      cfg_r.pulse_max       <= 12'd2000;
      cfg_r.deadband        <= 10'd40;
      cfg_r.max_forward     <= 8'd255;
      cfg_r.max_reverse     <= 9'h101;   // -255
      cfg_r.reverse_channel <= 1'b0;
      cfg_r.smoothing_shift <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        rtpd_pkg::REG_PULSE_MIN:       cfg_r.pulse_min       <= cfg_data[11:0];
        rtpd_pkg::REG_PULSE_CENTER:    cfg_r.pulse_center    <= cfg_data[11:0];
        rtpd_pkg::REG_PULSE_MAX:       cfg_r.pulse_max       <= cfg_data[11:0];
        rtpd_pkg::REG_DEADBAND:        cfg_r.deadband        <= cfg_data[9:0];
        rtpd_pkg::REG_MAX_FORWARD:     cfg_r.max_forward     <= cfg_data[7:0];
        rtpd_pkg::REG_MAX_REVERSE:     cfg_r.max_reverse     <= cfg_data[8:0];
        rtpd_pkg::REG_REVERSE_CHANNEL: cfg_r.reverse_channel <= cfg_data[0];
        rtpd_pkg::REG_SMOOTHING_SHIFT: cfg_r.smoothing_shift <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/rtpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtpd_ctrl
// Sequencer: steps one pulse through check, multiply, divide, raw and result, and
// owns the valid flag of the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rtpd_pkg::dp_cmd_t        cmd,
  input  wire rtpd_pkg::dp_stat_t  stat
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_MUL   = 6'b000100,
    S_DIV   = 6'b001000,
    S_RAW   = 6'b010000,
    S_RES   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.setup = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mult  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_RAW;
      end
      S_RAW: begin
        cmd.raw   = 1'b1;
        state_nxt = S_RES;
      end
      S_RES: begin
        if (out_free) begin
          cmd.result = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.result) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/rtpd_dp.sv =====
// ----------------------------------------------------------------------------
// rtpd_dp
// Datapath: bad-pulse check, side selection, multiply, restoring divide,
// saturation, exponential smoother, clamp and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpd_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire rtpd_pkg::cfg_t                    cfg,
  input  wire rtpd_pkg::dp_cmd_t                 cmd,
  output rtpd_pkg::dp_stat_t                     stat,
  input  wire logic [rtpd_pkg::PW_W-1:0]         in_pulse_width,
  output logic signed [rtpd_pkg::CMD_W-1:0]      out_command,
  output logic                                   out_failsafe
);

  localparam int DW = rtpd_pkg::DIV_W;
  localparam int NW = rtpd_pkg::DEN_W;
  localparam logic signed [9:0] ADJ = 10'(rtpd_pkg::CENTER_ADJUST);

  // Input capture.
  logic [rtpd_pkg::PW_W-1:0] p_r;

  // Setup stage.
  logic                bad_c;
  logic signed [14:0]  p_s, pmin_s, pmax_s, hi_edge, lo_edge;
  logic                fwd_side, rev_side;
  logic signed [14:0]  num_c, den_c, den_abs;
  logic signed [9:0]   fwd10, rev10, oa_c, ob_c;
  logic signed [10:0]  delta_c;

  logic                bad_r, side_r, zspan_r, den_neg_r;
  logic signed [14:0]  num_r;
  logic signed [10:0]  delta_r;
  logic signed [9:0]   oa_r;
  logic [NW-1:0]       den_mag_r;

  // Multiply and divide.
  logic signed [25:0]  prod_c, prod_abs;
  logic [DW-1:0]       dq_r;
  logic                q_neg_r;
  logic [NW-1:0]       rem_r;
  logic [rtpd_pkg::CNT_W-1:0] cnt_r;
  logic [NW:0]         trial, diff;
  logic                ge;

  // Raw value.
  logic signed [22:0]  q_ext, q_s;
  logic signed [23:0]  sum_c, mapped;
  logic signed [15:0]  raw_c, raw_r;

  // Smoother and clamp.
  logic signed [15:0]  s_r, s_new, val, rev16, fwd16, clamped;
  logic signed [16:0]  d_c, sh_c, s_sum;
  logic                smooth_on;
  logic signed [rtpd_pkg::CMD_W-1:0] out_command_r;
  logic                out_failsafe_r;

  always_ff @(posedge clk) begin
    if (cmd.load) p_r <= in_pulse_width;
  end

  always_comb begin
    bad_c = (p_r == '0) || (p_r > 16'(rtpd_pkg::PULSE_BAD_MAX)) ||
            (p_r < 16'(rtpd_pkg::PULSE_BAD_MIN));
    p_s     = $signed({3'b000, p_r[11:0]});
    pmin_s  = $signed({3'b000, cfg.pulse_min});
    pmax_s  = $signed({3'b000, cfg.pulse_max});
    hi_edge = $signed({3'b000, cfg.pulse_center}) + $signed({5'b00000, cfg.deadband});
    lo_edge = $signed({3'b000, cfg.pulse_center}) - $signed({5'b00000, cfg.deadband});
    fwd_side = (p_s >= hi_edge);
    rev_side = !fwd_side && (p_s <= lo_edge);
    fwd10 = $signed({2'b00, cfg.max_forward});
    rev10 = $signed({cfg.max_reverse[8], cfg.max_reverse});
    if (fwd_side) begin
      num_c = p_s - hi_edge;
      den_c = pmax_s - hi_edge;
      oa_c  = cfg.reverse_channel ? -ADJ : ADJ;
      ob_c  = cfg.reverse_channel ? rev10 : fwd10;
    end else begin
      num_c = p_s - pmin_s;
      den_c = lo_edge - pmin_s;
      oa_c  = cfg.reverse_channel ? fwd10 : rev10;
      ob_c  = cfg.reverse_channel ? -ADJ : ADJ;
    end
    delta_c = $signed({ob_c[9], ob_c}) - $signed({oa_c[9], oa_c});
    den_abs = den_c[14] ? -den_c : den_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      bad_r     <= bad_c;
      side_r    <= fwd_side || rev_side;
      zspan_r   <= (den_c == '0);
      num_r     <= num_c;
      delta_r   <= delta_c;
      oa_r      <= oa_c;
      den_mag_r <= den_abs[NW-1:0];
      den_neg_r <= den_c[14];
    end
  end

  // The divide works on magnitudes; the quotient sign is restored afterwards,
  // which gives truncation toward zero.
  always_comb begin
    prod_c   = num_r * delta_r;
    prod_abs = prod_c[25] ? -prod_c : prod_c;
    trial    = {rem_r, dq_r[DW-1]};
    ge       = (trial >= {1'b0, den_mag_r});
    diff     = trial - {1'b0, den_mag_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      dq_r    <= prod_abs[DW-1:0];
      q_neg_r <= prod_c[25] ^ den_neg_r;
      rem_r   <= '0;
      cnt_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[NW-1:0] : trial[NW-1:0];
      dq_r  <= {dq_r[DW-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign stat.div_last = (cnt_r == rtpd_pkg::CNT_W'(DW - 1));

  always_comb begin
    q_ext  = $signed({1'b0, dq_r});
    q_s    = q_neg_r ? -q_ext : q_ext;
    sum_c  = $signed({{14{oa_r[9]}}, oa_r}) + $signed({q_s[22], q_s});
    mapped = zspan_r ? $signed({{14{oa_r[9]}}, oa_r}) : sum_c;
    if (bad_r || !side_r) raw_c = '0;
    else if (mapped > 24'sd32767) raw_c = 16'sh7fff;
    else if (mapped < -24'sd32768) raw_c = 16'sh8000;
    else raw_c = mapped[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.raw) raw_r <= raw_c;
  end

  // The step lies between the state and the raw value, so 16 bits suffice.
  always_comb begin
    d_c       = $signed({raw_r[15], raw_r}) - $signed({s_r[15], s_r});
    sh_c      = d_c >>> cfg.smoothing_shift;
    s_sum     = $signed({s_r[15], s_r}) + sh_c;
    s_new     = s_sum[15:0];
    smooth_on = (cfg.smoothing_shift != 3'd0) && !bad_r;
    val       = smooth_on ? s_new : raw_r;
    rev16     = $signed({{7{cfg.max_reverse[8]}}, cfg.max_reverse});
    fwd16     = $signed({8'h00, cfg.max_forward});
    if (val < rev16) clamped = rev16;
    else if (val > fwd16) clamped = fwd16;
    else clamped = val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else if (cmd.result && smooth_on) begin
      s_r <= s_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      out_command_r  <= clamped[rtpd_pkg::CMD_W-1:0];
      out_failsafe_r <= bad_r;
    end
  end

  assign out_command  = out_command_r;
  assign out_failsafe = out_failsafe_r;

endmodule

`default_nettype wire

// ===== rtl/rc_throttle_pulse_decoder.sv =====
// ----------------------------------------------------------------------------
// rc_throttle_pulse_decoder
// Converts a measured RC servo pulse width into a signed throttle command.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_pulse_width) carries one pulse
//   width in microseconds per transfer. The output channel (out_valid,
//   out_stall, out_command, out_failsafe) returns one result per pulse.
//   Registers must be written by the user through cfg_we, cfg_index and
//   cfg_data only while the block is idle; the block does not enforce it.
//   Each pulse passes through the check, multiply, divide, saturate and result
//   steps; the divide is a 22-step restoring divider of the linear map, one
//   quotient bit per cycle. A new pulse is taken only once the previous one
//   has passed its result step.
//   in_stall is high while a pulse is being processed. If the receiver stalls,
//   the result is held in the output register, and a following pulse is
//   taken and processed; it waits before the result step until the
//   register drains.
//   Reset (rst_n low at a clock edge) restores the register defaults, clears
//   the smoothing state and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_throttle_pulse_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [rtpd_pkg::PW_W-1:0]         in_pulse_width,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [rtpd_pkg::CMD_W-1:0]      out_command,
  output logic                                   out_failsafe,
  input  wire logic                              cfg_we,
  input  wire logic [rtpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rtpd_pkg::CFG_W-1:0]        cfg_data
);

  rtpd_pkg::cfg_t     cfg;
  rtpd_pkg::dp_cmd_t  cmd;
  rtpd_pkg::dp_stat_t stat;

  rtpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rtpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  rtpd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .stat           (stat),
    .in_pulse_width (in_pulse_width),
    .out_command    (out_command),
    .out_failsafe   (out_failsafe)
  );

endmodule

`default_nettype wire
